### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the encoder RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/cenc_pkg.sv
// ----------------------------------------------------------------------------
// Convolutional encoder package
// Widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package cenc_pkg;

    localparam int SLOT_W      = 16;
    localparam int SR_W        = 16;
    localparam int NUM_SLOTS   = 7;
    localparam int LOW_SLOTS   = 4;
    localparam int HIGH_SLOTS  = 3;
    localparam int CODE_W      = 7;
    localparam int CNT_W       = 4;
    localparam int OCNT_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int GEN_HIGH_W  = 48;

    localparam logic OP_ENCODE    = 1'b0;
    localparam logic OP_TERMINATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECURSIVE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATORS_LOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATORS_HIGH = 2'd3;

    localparam logic [OCNT_W-1:0]     RST_OUTPUT_COUNT = 3'd2;
    localparam logic [CFG_DATA_W-1:0] RST_GEN_LOW      = 64'd5963897;
    localparam logic [GEN_HIGH_W-1:0] RST_GEN_HIGH     = 48'd0;

    // The feedback tap of generator 0 never uses its lowest bit.
    localparam logic [SLOT_W-1:0] FEEDBACK_TAP_MASK = ~16'h0001;

    typedef struct packed {
        logic [OCNT_W-1:0]                 out_count;
        logic                              rsc;
        logic [SR_W-1:0]                   sr_mask;
        logic [CNT_W-1:0]                  order;
        logic [NUM_SLOTS-1:0][SLOT_W-1:0]  gens;
    } t_code_cfg;

endpackage

### hdl/cenc_in_if.sv
// ----------------------------------------------------------------------------
// Encoder input channel
// Valid/ready channel carrying one opcode and one data bit per transfer.
// ----------------------------------------------------------------------------
interface cenc_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic data_bit;

    modport source (output valid, output opcode, output data_bit, input ready);
    modport sink   (input valid, input opcode, input data_bit, output ready);
endinterface

### hdl/cenc_out_if.sv
// ----------------------------------------------------------------------------
// Encoder output channel
// Valid/ready channel carrying one coded symbol and its last flag.
// ----------------------------------------------------------------------------
interface cenc_out_if;
    import cenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_bits;
    logic              last;

    modport source (output valid, output code_bits, output last, input ready);
    modport sink   (input valid, input code_bits, input last, output ready);
endinterface

### hdl/convolutional_encoder.sv
// ----------------------------------------------------------------------------
// Convolutional encoder
// Rate 1/n feedforward or recursive systematic encoder with zero flush.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on i_item (opcode, data_bit) and coded symbols leave on
// o_result (code_bits, last); both are valid/ready channels. An encode item
// yields one symbol with last set. A terminate item yields order+1 symbols,
// one per cycle while the receiver does not stall, the final one with last
// set; order is the highest set bit over the generators in use.
// The configuration port is written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write it only while no item is in flight; the block does not enforce this.
// An input transfer is captured in the input register; the step logic ahead
// of the output register then computes its symbol and loads it there.
// Throughput is one symbol per cycle while the receiver does not stall, set by
// the single step unit feeding the output register.
// Reset clears the shift register, empties both registers and loads the
// default code registers. When the receiver stalls, the output register holds
// its symbol and the input register still takes one more item if it is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module convolutional_encoder #(
    parameter int GENERATOR_WIDTH = 16,
    parameter int MAX_OUTPUTS     = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cenc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cenc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cenc_in_if.sink                            i_item,
    cenc_out_if.source                         o_result
);
    import cenc_pkg::*;

    t_code_cfg w_cfg;

    logic              r_in_valid;
    logic              r_op;
    logic              r_bit;
    logic [CNT_W-1:0]  r_cnt;
    logic [SR_W-1:0]   r_sr;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_last;

    logic [CNT_W-1:0]  n_cnt;
    logic [SR_W-1:0]   n_sr;
    logic [CODE_W-1:0] n_code;

    logic w_out_free;
    logic w_fire;
    logic w_is_last;
    logic w_consume;
    logic w_in_xfer;

    cenc_cfg #(
        .GENERATOR_WIDTH (GENERATOR_WIDTH),
        .MAX_OUTPUTS     (MAX_OUTPUTS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cenc_step u_step (
        .i_cfg     (w_cfg),
        .i_sr      (r_sr),
        .i_flush   (r_op == OP_TERMINATE),
        .i_bit     (r_bit),
        .o_next_sr (n_sr),
        .o_code    (n_code)
    );

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_is_last  = (r_op == OP_ENCODE) || (r_cnt == w_cfg.order);
    assign w_consume  = w_fire && w_is_last;
    assign w_in_xfer  = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || w_consume;

    always_comb begin
        if (w_consume) begin
            n_cnt = '0;
        end else if (w_fire) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cnt       <= '0;
            r_sr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
            if (w_fire) begin
                r_sr        <= n_sr;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op  <= i_item.opcode;
            r_bit <= i_item.data_bit;
        end
        if (w_fire) begin
            r_out_code <= n_code;
            r_out_last <= w_is_last;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.code_bits = r_out_code;
    assign o_result.last      = r_out_last;

    `ASSERT_NEXT(a_fire_loads_output, i_clk, i_rst_n, w_fire,
        r_out_valid && (r_out_last == $past(w_consume)), "step did not load the output register")
    `ASSERT_IMPL(a_encode_single_symbol, i_clk, i_rst_n, w_fire && (r_op == OP_ENCODE),
        w_consume, "encode item was not retired with its symbol")
    `ASSERT_IMPL(a_idle_count_zero, i_clk, i_rst_n, !r_in_valid,
        r_cnt == '0, "flush count not cleared while no item is held")

endmodule

### hdl/cenc_cfg.sv
// ----------------------------------------------------------------------------
// Encoder configuration registers
// Holds the code registers and derives the active output count, the masked
// generators and the memory order.
// ----------------------------------------------------------------------------
module cenc_cfg #(
    parameter int GENERATOR_WIDTH = 16,
    parameter int MAX_OUTPUTS     = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cenc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cenc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cenc_pkg::t_code_cfg                 o_cfg
);
    import cenc_pkg::*;

    localparam int EFF_W = (GENERATOR_WIDTH < SLOT_W) ? GENERATOR_WIDTH : SLOT_W;

    logic [OCNT_W-1:0]     r_output_count;
    logic                  r_recursive_mode;
    logic [CFG_DATA_W-1:0] r_gen_low;
    logic [GEN_HIGH_W-1:0] r_gen_high;

    logic [SR_W-1:0]                  w_mask;
    logic [OCNT_W-1:0]                w_count;
    logic [NUM_SLOTS-1:0][SLOT_W-1:0] w_gens;
    logic [SLOT_W-1:0]                w_used_or;
    logic [CNT_W-1:0]                 w_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_count   <= RST_OUTPUT_COUNT;
            r_recursive_mode <= 1'b0;
            r_gen_low        <= RST_GEN_LOW;
            r_gen_high       <= RST_GEN_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OUTPUT_COUNT:    r_output_count   <= i_cfg_data[OCNT_W-1:0];
                REG_RECURSIVE_MODE:  r_recursive_mode <= i_cfg_data[0];
                REG_GENERATORS_LOW:  r_gen_low        <= i_cfg_data;
                REG_GENERATORS_HIGH: r_gen_high       <= i_cfg_data[GEN_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < SR_W; b++) begin
            w_mask[b] = (b < EFF_W);
        end
    end

    // A zero count acts as one; counts above the build limit saturate.
    always_comb begin
        w_count = r_output_count;
        if (r_output_count == '0) begin
            w_count = OCNT_W'(1);
        end else if (32'(r_output_count) > MAX_OUTPUTS) begin
            w_count = OCNT_W'(MAX_OUTPUTS);
        end
    end

    always_comb begin
        for (int p = 0; p < LOW_SLOTS; p++) begin
            w_gens[p] = r_gen_low[p*SLOT_W +: SLOT_W] & w_mask;
        end
        for (int p = 0; p < HIGH_SLOTS; p++) begin
            w_gens[p+LOW_SLOTS] = r_gen_high[p*SLOT_W +: SLOT_W] & w_mask;
        end
    end

    always_comb begin
        w_used_or = '0;
        for (int p = 0; p < NUM_SLOTS; p++) begin
            if (p < 32'(w_count)) begin
                w_used_or = w_used_or | w_gens[p];
            end
        end
        w_order = '0;
        for (int b = 0; b < SLOT_W; b++) begin
            if (w_used_or[b]) begin
                w_order = CNT_W'(b);
            end
        end
    end

    always_comb begin
        o_cfg.out_count = w_count;
        o_cfg.rsc       = r_recursive_mode;
        o_cfg.sr_mask   = w_mask;
        o_cfg.order     = w_order;
        o_cfg.gens      = w_gens;
    end

endmodule

### hdl/cenc_step.sv
// ----------------------------------------------------------------------------
// Encoder step
// One trellis step: the next shift register contents and the coded symbol,
// for feedforward and recursive systematic codes.
// ----------------------------------------------------------------------------
module cenc_step (
    input  cenc_pkg::t_code_cfg              i_cfg,
    input  logic [cenc_pkg::SR_W-1:0]        i_sr,
    input  logic                             i_flush,
    input  logic                             i_bit,
    output logic [cenc_pkg::SR_W-1:0]        o_next_sr,
    output logic [cenc_pkg::CODE_W-1:0]      o_code
);
    import cenc_pkg::*;

    logic [SR_W-1:0] w_shifted;
    logic            w_fb;
    logic            w_in;

    assign w_shifted = {i_sr[SR_W-2:0], 1'b0};
    assign w_fb      = ^(w_shifted & i_cfg.gens[0] & FEEDBACK_TAP_MASK);

    always_comb begin
        if (i_flush) begin
            w_in = 1'b0;
        end else if (i_cfg.rsc) begin
            w_in = i_bit ^ w_fb;
        end else begin
            w_in = i_bit;
        end
    end

    assign o_next_sr = (w_shifted | SR_W'(w_in)) & i_cfg.sr_mask;

    // In the systematic code output 0 carries the raw bit, or the feedback
    // parity while the register is being flushed.
    always_comb begin
        o_code = '0;
        for (int p = 0; p < CODE_W; p++) begin
            if (p < 32'(i_cfg.out_count)) begin
                o_code[p] = ^(o_next_sr & i_cfg.gens[p]);
            end
        end
        if (i_cfg.rsc) begin
            o_code[0] = i_flush ? w_fb : i_bit;
        end
    end

endmodule

### dv/cenc_symbol_checker.sv
// ----------------------------------------------------------------------------
// Coded symbol checker
// Watches the configuration port and both encoder channels, keeps its own
// copy of the code registers and the shift register, predicts the symbols
// of every input transfer and compares them in order with the output.
// ----------------------------------------------------------------------------
module cenc_symbol_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cenc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cenc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cenc_in_if                              i_item,
    cenc_out_if                             i_result,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cenc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic              last;
    } t_symbol;

    t_symbol                 expected_symbols[$];
    logic [OCNT_W-1:0]       out_count;
    logic                    rsc;
    logic [CFG_DATA_W-1:0]   gen_low;
    logic [GEN_HIGH_W-1:0]   gen_high;
    logic [SR_W-1:0]         code_state;
    int                      fail_total = 0;

    function automatic logic [SLOT_W-1:0] tap_of(int p);
        if (p < LOW_SLOTS) return gen_low[SLOT_W*p +: SLOT_W];
        return gen_high[SLOT_W*(p-LOW_SLOTS) +: SLOT_W];
    endfunction

    function automatic int stream_count();
        return (out_count == '0) ? 1 : int'(out_count);
    endfunction

    // A flush runs one step per register stage up to the highest tap in use.
    function automatic int flush_steps(int n);
        int ord;
        logic [SLOT_W-1:0] g;
        ord = 0;
        for (int p = 0; p < n; p++) begin
            g = tap_of(p);
            for (int b = 0; b < SLOT_W; b++) begin
                if (g[b] && b > ord) ord = b;
            end
        end
        return ord + 1;
    endfunction

    function automatic logic [CODE_W-1:0] next_symbol(int n, logic flush, logic din);
        logic [CODE_W-1:0] sym;
        logic fb;
        int first;
        sym   = '0;
        first = 0;
        if (rsc) begin
            // The systematic bit on a flush is the feedback parity of the shifted register.
            fb = ^({code_state[SR_W-2:0], 1'b0} & tap_of(0) & FEEDBACK_TAP_MASK);
            sym[0] = flush ? fb : din;
            code_state = {code_state[SR_W-2:0], flush ? 1'b0 : (din ^ fb)};
            first = 1;
        end else begin
            code_state = {code_state[SR_W-2:0], flush ? 1'b0 : din};
        end
        for (int p = first; p < n; p++) sym[p] = ^(code_state & tap_of(p));
        return sym;
    endfunction

    task automatic predict_symbols(logic op, logic din);
        int n;
        int steps;
        t_symbol s;
        n = stream_count();
        if (op == OP_ENCODE) begin
            s.code_bits = next_symbol(n, 1'b0, din);
            s.last      = 1'b1;
            expected_symbols.push_back(s);
        end else begin
            steps = flush_steps(n);
            for (int k = 0; k < steps; k++) begin
                s.code_bits = next_symbol(n, 1'b1, 1'b0);
                s.last      = (k == steps - 1);
                expected_symbols.push_back(s);
            end
        end
    endtask

    task automatic compare_symbol(logic [CODE_W-1:0] code_bits, logic last);
        t_symbol want;
        if (expected_symbols.size() == 0) begin
            $error("symbol with nothing pending: code_bits %0h, last %0b", code_bits, last);
            fail_total++;
        end else begin
            want = expected_symbols.pop_front();
            if (code_bits !== want.code_bits) begin
                $error("code_bits: expected %0h, actual %0h", want.code_bits, code_bits);
                fail_total++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_count  = RST_OUTPUT_COUNT;
            rsc        = 1'b0;
            gen_low    = RST_GEN_LOW;
            gen_high   = RST_GEN_HIGH;
            code_state = '0;
            expected_symbols.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OUTPUT_COUNT:    out_count = i_cfg_data[OCNT_W-1:0];
                    REG_RECURSIVE_MODE:  rsc       = i_cfg_data[0];
                    REG_GENERATORS_LOW:  gen_low   = i_cfg_data;
                    REG_GENERATORS_HIGH: gen_high  = i_cfg_data[GEN_HIGH_W-1:0];
                    default: ;
                endcase
            end
            // Outputs belong to older items, so they are checked first.
            if (i_result.valid && i_result.ready)
                compare_symbol(i_result.code_bits, i_result.last);
            if (i_item.valid && i_item.ready)
                predict_symbols(i_item.opcode, i_item.data_bit);
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_symbols.size();
    end

endmodule

### dv/tb_convolutional_encoder.sv
// ----------------------------------------------------------------------------
// Convolutional encoder testbench
// Drives encode and terminate items through several code settings and
// idling patterns; the symbol checker predicts and compares every symbol.
// ----------------------------------------------------------------------------
module tb_convolutional_encoder;
    import cenc_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct;
    int                    stall_pct;
    bit                    hold_req;

    cenc_in_if  u_item_if ();
    cenc_out_if u_result_if ();

    convolutional_encoder u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (u_item_if),
        .o_result   (u_result_if)
    );

    cenc_symbol_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (u_item_if),
        .i_result     (u_result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        u_result_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                u_result_if.ready <= 1'b0;
            end else begin
                u_result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_item(logic op, logic din);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            u_item_if.valid <= 1'b0;
            @(posedge clk);
        end
        u_item_if.valid    <= 1'b1;
        u_item_if.opcode   <= op;
        u_item_if.data_bit <= din;
        do @(posedge clk); while (!u_item_if.ready);
    endtask

    // Stop offering items and wait until every predicted symbol has arrived.
    task automatic drain();
        u_item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] count, logic [CFG_DATA_W-1:0] mode,
                             logic [CFG_DATA_W-1:0] glow, logic [CFG_DATA_W-1:0] ghigh);
        cfg_write(REG_OUTPUT_COUNT, count);
        cfg_write(REG_RECURSIVE_MODE, mode);
        cfg_write(REG_GENERATORS_LOW, glow);
        cfg_write(REG_GENERATORS_HIGH, ghigh);
        cfg_we <= 1'b0;
    endtask

    // Blocks of random data bits closed by a terminate, with stray terminates.
    task automatic random_items(int count, bit pause_midway);
        int run_left;
        run_left = $urandom_range(0, 12);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) drain();
            if (run_left == 0 || $urandom_range(0, 19) == 0) begin
                send_item(OP_TERMINATE, 1'($urandom_range(0, 1)));
                run_left = $urandom_range(0, 12);
            end else begin
                send_item(OP_ENCODE, 1'($urandom_range(0, 1)));
                run_left--;
            end
        end
    endtask

    initial begin
        int phase_count[6];
        logic [SLOT_W-1:0] slot_mask;
        logic [CFG_DATA_W-1:0] glow;
        logic [CFG_DATA_W-1:0] ghigh;
        phase_count = '{7, 3, 0, 5, 1, 6};
        send_idle_pct      = 0;
        stall_pct          = 0;
        hold_req           = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        u_item_if.valid    = 1'b0;
        u_item_if.opcode   = OP_ENCODE;
        u_item_if.data_bit = 1'b0;
        rst_n              = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Default code: a terminate right after another flushes an empty register.
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b0);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_TERMINATE, 1'b1);
        send_item(OP_TERMINATE, 1'b0);
        drain();

        // Every tap set and seven outputs: the longest flush.
        configure(64'd7, 64'd0, '1, '1);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b0);
        send_item(OP_TERMINATE, 1'b0);
        drain();

        // Zero output count behaves as one output, recursive code.
        configure(64'd0, 64'd1, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b0);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_TERMINATE, 1'b1);
        drain();

        // All generators zero: a terminate gives a single symbol.
        configure(64'd1, 64'd1, '0, '0);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_TERMINATE, 1'b0);
        send_item(OP_ENCODE, 1'b0);
        send_item(OP_TERMINATE, 1'b1);
        drain();

        // Count written with upper bits set; feedback taps reach the top stage.
        configure(64'd15, '1, {$urandom, $urandom} | 64'h8001, '1);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b1);
        send_item(OP_ENCODE, 1'b0);
        send_item(OP_TERMINATE, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            // Masking the taps spreads the memory order across the phases.
            slot_mask = SLOT_W'((32'h1 << $urandom_range(1, SLOT_W)) - 1);
            glow  = {$urandom, $urandom} & {LOW_SLOTS{slot_mask}};
            ghigh = {$urandom, $urandom} & {LOW_SLOTS{slot_mask}};
            configure(CFG_DATA_W'(phase_count[ph]), CFG_DATA_W'(ph % 2), glow, ghigh);
            if (ph == 4) hold_req = 1'b1;
            random_items(25, ph == 4);
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/cenc_pkg.sv
hdl/cenc_in_if.sv
hdl/cenc_out_if.sv
hdl/cenc_cfg.sv
hdl/cenc_step.sv
hdl/convolutional_encoder.sv
dv/cenc_symbol_checker.sv
dv/tb_convolutional_encoder.sv
